[rtl/core/x86ie_pkg.sv]
// x86ie_pkg: shared types, opcode codes, byte constants and encode helpers
// for the x86-64 instruction encoder unit; depends on nothing else
package x86ie_pkg;

   localparam int MaxBytes   = 11;
   localparam int CountW     = 4;
   localparam int QueueDepth = 4;

   typedef enum logic [4:0] {
      OP_PUSH_RBP     = 5'd0,
      OP_MOV_RBP_RSP  = 5'd1,
      OP_MOV_RSP_RBP  = 5'd2,
      OP_POP_RBP      = 5'd3,
      OP_RET          = 5'd4,
      OP_SUB_RSP      = 5'd5,
      OP_ADD_RSP      = 5'd6,
      OP_MOV_REG_IMM  = 5'd7,
      OP_MOV_REG_REG  = 5'd8,
      OP_MOV_RAX_IMM64 = 5'd9,
      OP_ADD_REG_IMM  = 5'd10,
      OP_SUB_REG_IMM  = 5'd11,
      OP_XOR_REG_REG  = 5'd12,
      OP_CALL         = 5'd13,
      OP_JMP          = 5'd14,
      OP_NOP          = 5'd15,
      OP_PROLOGUE     = 5'd16,
      OP_EPILOGUE     = 5'd17,
      OP_RAW_BYTE     = 5'd18,
      OP_RAW_REX      = 5'd19,
      OP_RAW_MODRM    = 5'd20,
      OP_RAW_SIB      = 5'd21
   } op_type;

   localparam logic [7:0] RexBase   = 8'h40;
   localparam logic [7:0] RexW      = 8'h08;
   localparam logic [7:0] OpAluImm8 = 8'h83;
   localparam logic [7:0] OpAluImm32 = 8'h81;
   localparam logic [7:0] OpMovRm   = 8'h89;
   localparam logic [7:0] OpXorRm   = 8'h31;
   localparam logic [7:0] OpMovImm64 = 8'hB8;
   localparam logic [7:0] OpMovImm32 = 8'hC7;
   localparam logic [7:0] OpCall    = 8'hE8;
   localparam logic [7:0] OpJmp     = 8'hE9;
   localparam logic [7:0] OpPushRbp = 8'h55;
   localparam logic [7:0] OpPopRbp  = 8'h5D;
   localparam logic [7:0] OpRet     = 8'hC3;
   localparam logic [7:0] OpNop     = 8'h90;

   localparam logic [2:0] ExtAdd = 3'd0;
   localparam logic [2:0] ExtSub = 3'd5;
   localparam logic [3:0] RegRsp = 4'd4;
   localparam logic [3:0] RegRbp = 4'd5;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountW-1:0]        count;
   } desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
      return {md, rg, rm};
   endfunction

   function automatic desc_type put_byte(desc_type d, logic [7:0] b);
      desc_type r;
      r = d;
      if (d.count < CountW'(MaxBytes)) begin
         r.bytes[d.count] = b;
         r.count = d.count + CountW'(1);
      end
      return r;
   endfunction

   function automatic desc_type put32(desc_type d, logic [31:0] v);
      desc_type r;
      r = put_byte(d, v[7:0]);
      r = put_byte(r, v[15:8]);
      r = put_byte(r, v[23:16]);
      r = put_byte(r, v[31:24]);
      return r;
   endfunction

   // REX.W (+B) then 83 ib or 81 id with ModRM /ext
   function automatic desc_type arith_imm(desc_type d, logic [2:0] ext, logic [3:0] rm,
                                          logic [31:0] v);
      desc_type r;
      logic     fits8;
      fits8 = (v[31:7] == '0) || (v[31:7] == '1);
      r = put_byte(d, RexBase | RexW | {7'd0, rm[3]});
      if (fits8) begin
         r = put_byte(r, OpAluImm8);
         r = put_byte(r, modrm(2'd3, ext, rm[2:0]));
         r = put_byte(r, v[7:0]);
      end else begin
         r = put_byte(r, OpAluImm32);
         r = put_byte(r, modrm(2'd3, ext, rm[2:0]));
         r = put32(r, v);
      end
      return r;
   endfunction

   // REX.W R B, op, ModRM(3, src, dst)
   function automatic desc_type reg_reg(desc_type d, logic [7:0] op, logic [3:0] dst,
                                        logic [3:0] src);
      desc_type r;
      r = put_byte(d, RexBase | RexW | {5'd0, src[3], 1'b0, dst[3]});
      r = put_byte(r, op);
      r = put_byte(r, modrm(2'd3, src[2:0], dst[2:0]));
      return r;
   endfunction

endpackage

[rtl/core/x86ie_if.sv]
// x86ie_req_if and x86ie_rsp_if: valid/ready channels of the encoder
// depends on nothing else
interface x86ie_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  opcode;
   logic [3:0]  dst_reg;
   logic [3:0]  src_reg;
   logic [63:0] imm;
   logic [1:0]  two_bit_field;
   logic [3:0]  rex_bits;

   modport source (output valid, opcode, dst_reg, src_reg, imm, two_bit_field, rex_bits,
                   input ready);
   modport sink   (input valid, opcode, dst_reg, src_reg, imm, two_bit_field, rex_bits,
                   output ready);
endinterface

interface x86ie_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last;

   modport source (output valid, code_byte, last, input ready);
   modport sink   (input valid, code_byte, last, output ready);
endinterface

[rtl/core/x86ie_front.sv]
// x86ie_front: accepts requests and expands each into a byte descriptor
// depends on x86ie_pkg and x86ie_req_if
module x86ie_front (
   x86ie_req_if.sink               req_ch,
   input  x86ie_pkg::q_status_type q_stat,
   output logic                    push,
   output x86ie_pkg::desc_type     push_desc
);

   x86ie_pkg::desc_type d;
   logic [31:0]         lo;
   logic                stack_pos;

   assign lo        = req_ch.imm[31:0];
   assign stack_pos = (lo != '0) && !lo[31];

   always_comb begin
      d = '0;
      case (x86ie_pkg::op_type'(req_ch.opcode))
         x86ie_pkg::OP_PUSH_RBP: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpPushRbp);
         end
         x86ie_pkg::OP_MOV_RBP_RSP: begin
            d = x86ie_pkg::reg_reg(d, x86ie_pkg::OpMovRm, x86ie_pkg::RegRbp,
                                   x86ie_pkg::RegRsp);
         end
         x86ie_pkg::OP_MOV_RSP_RBP: begin
            d = x86ie_pkg::reg_reg(d, x86ie_pkg::OpMovRm, x86ie_pkg::RegRsp,
                                   x86ie_pkg::RegRbp);
         end
         x86ie_pkg::OP_POP_RBP: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpPopRbp);
         end
         x86ie_pkg::OP_RET: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpRet);
         end
         x86ie_pkg::OP_SUB_RSP: begin
            d = x86ie_pkg::arith_imm(d, x86ie_pkg::ExtSub, x86ie_pkg::RegRsp, lo);
         end
         x86ie_pkg::OP_ADD_RSP: begin
            d = x86ie_pkg::arith_imm(d, x86ie_pkg::ExtAdd, x86ie_pkg::RegRsp, lo);
         end
         x86ie_pkg::OP_MOV_REG_IMM: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::RexBase | x86ie_pkg::RexW
                                       | {7'd0, req_ch.dst_reg[3]});
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpMovImm32);
            d = x86ie_pkg::put_byte(d, x86ie_pkg::modrm(2'd3, 3'd0, req_ch.dst_reg[2:0]));
            d = x86ie_pkg::put32(d, lo);
         end
         x86ie_pkg::OP_MOV_REG_REG: begin
            d = x86ie_pkg::reg_reg(d, x86ie_pkg::OpMovRm, req_ch.dst_reg, req_ch.src_reg);
         end
         x86ie_pkg::OP_MOV_RAX_IMM64: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::RexBase | x86ie_pkg::RexW);
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpMovImm64);
            d = x86ie_pkg::put32(d, lo);
            d = x86ie_pkg::put32(d, req_ch.imm[63:32]);
         end
         x86ie_pkg::OP_ADD_REG_IMM: begin
            d = x86ie_pkg::arith_imm(d, x86ie_pkg::ExtAdd, req_ch.dst_reg, lo);
         end
         x86ie_pkg::OP_SUB_REG_IMM: begin
            d = x86ie_pkg::arith_imm(d, x86ie_pkg::ExtSub, req_ch.dst_reg, lo);
         end
         x86ie_pkg::OP_XOR_REG_REG: begin
            d = x86ie_pkg::reg_reg(d, x86ie_pkg::OpXorRm, req_ch.dst_reg, req_ch.src_reg);
         end
         x86ie_pkg::OP_CALL: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpCall);
            d = x86ie_pkg::put32(d, lo);
         end
         x86ie_pkg::OP_JMP: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpJmp);
            d = x86ie_pkg::put32(d, lo);
         end
         x86ie_pkg::OP_NOP: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpNop);
         end
         x86ie_pkg::OP_PROLOGUE: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpPushRbp);
            d = x86ie_pkg::reg_reg(d, x86ie_pkg::OpMovRm, x86ie_pkg::RegRbp,
                                   x86ie_pkg::RegRsp);
            // frame allocation only for a positive stack size
            if (stack_pos) begin
               d = x86ie_pkg::arith_imm(d, x86ie_pkg::ExtSub, x86ie_pkg::RegRsp, lo);
            end
         end
         x86ie_pkg::OP_EPILOGUE: begin
            d = x86ie_pkg::reg_reg(d, x86ie_pkg::OpMovRm, x86ie_pkg::RegRsp,
                                   x86ie_pkg::RegRbp);
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpPopRbp);
            d = x86ie_pkg::put_byte(d, x86ie_pkg::OpRet);
         end
         x86ie_pkg::OP_RAW_BYTE: begin
            d = x86ie_pkg::put_byte(d, req_ch.imm[7:0]);
         end
         x86ie_pkg::OP_RAW_REX: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::RexBase | {4'd0, req_ch.rex_bits});
         end
         x86ie_pkg::OP_RAW_MODRM, x86ie_pkg::OP_RAW_SIB: begin
            d = x86ie_pkg::put_byte(d, x86ie_pkg::modrm(req_ch.two_bit_field,
                                                        req_ch.dst_reg[2:0],
                                                        req_ch.src_reg[2:0]));
         end
         default: begin
            d = '0;
         end
      endcase
   end

   // unused opcodes produce no bytes and are dropped at the transfer
   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full && (d.count != '0);
   assign push_desc    = d;

endmodule

[rtl/core/x86ie_queue.sv]
// x86ie_queue: small descriptor fifo between the front and back parts
// depends on x86ie_pkg
module x86ie_queue #(
   parameter int QUEUE_DEPTH = x86ie_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  x86ie_pkg::desc_type     push_desc,
   input  logic                    pop,
   output x86ie_pkg::desc_type     head,
   output x86ie_pkg::q_status_type q_stat
);

   localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FillW = $clog2(QUEUE_DEPTH + 1);

   x86ie_pkg::desc_type mem [QUEUE_DEPTH];
   x86ie_pkg::desc_type head_ff;
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0]    fill_ff, fill_in;
   logic                do_push, do_pop;

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FillW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // head is read ahead at the next read pointer, bypassing a write to that slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
      if (do_push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_desc;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign head         = head_ff;
   assign q_stat.empty = (fill_ff == '0);
   assign q_stat.full  = (fill_ff == FillW'(QUEUE_DEPTH));

endmodule

[rtl/core/x86ie_back.sv]
// x86ie_back: walks the head descriptor and sends one byte per transfer
// depends on x86ie_pkg and x86ie_rsp_if
module x86ie_back (
   input  logic                    clock,
   input  logic                    reset,
   input  x86ie_pkg::desc_type     head,
   input  x86ie_pkg::q_status_type q_stat,
   output logic                    pop,
   x86ie_rsp_if.source             rsp_ch
);

   localparam int IdxW = $clog2(x86ie_pkg::MaxBytes);

   logic [IdxW-1:0] idx_ff, idx_in;
   logic            xfer;
   logic            is_last;

   assign is_last = (x86ie_pkg::CountW'(idx_ff) == head.count - x86ie_pkg::CountW'(1));
   assign xfer    = rsp_ch.valid && rsp_ch.ready;
   assign pop     = xfer && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (xfer) begin
         idx_in = is_last ? '0 : idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign rsp_ch.valid     = !q_stat.empty;
   assign rsp_ch.code_byte = head.bytes[idx_ff];
   assign rsp_ch.last      = is_last;

endmodule

[rtl/core/x86_64_instruction_encoder_unit.sv]
// x86_64_instruction_encoder_unit: top level of the x86-64 instruction encoder
// the first byte of an item is offered from the registered queue head after those ahead of it
// throughput: one byte per cycle while the receiver is ready; an item holds the output
// through its 1 to 11 byte transfers, set by the single byte lane of the back part
// the front takes a new item each cycle while the descriptor queue has room
// reset (synchronous) empties the queue and rewinds the byte index
module x86_64_instruction_encoder_unit #(
   parameter int QUEUE_DEPTH = x86ie_pkg::QueueDepth
) (
   input logic         clock,
   input logic         reset,
   x86ie_req_if.sink   req_ch,
   x86ie_rsp_if.source rsp_ch
);

   logic                    push;
   logic                    pop;
   x86ie_pkg::desc_type     push_desc;
   x86ie_pkg::desc_type     head;
   x86ie_pkg::q_status_type q_stat;

   x86ie_front u_front (
      .req_ch    (req_ch),
      .q_stat    (q_stat),
      .push      (push),
      .push_desc (push_desc)
   );

   x86ie_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   x86ie_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // a queued descriptor always carries between one and eleven bytes
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (head.count != '0)
                       && (head.count <= x86ie_pkg::CountW'(x86ie_pkg::MaxBytes)))
      else $error("queued descriptor with bad byte count");

   // an item pushed into an empty queue is offered on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push && q_stat.empty) |=> rsp_ch.valid)
      else $error("pushed item not offered");

   // after a byte that is not the last, the same item keeps the output
   a_more_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=> rsp_ch.valid)
      else $error("item cut off before its last byte");

endmodule

[tb/x86_64_instruction_encoder_unit_test.sv]
`timescale 1ns / 1ps
// x86_64_instruction_encoder_unit_test: directed rows, then random encode requests
// under sender idling and receiver stalls, each code byte checked in order
// depends on x86ie_pkg, x86ie_req_if, x86ie_rsp_if and x86_64_instruction_encoder_unit
module x86_64_instruction_encoder_unit_test;

   localparam int CycleLimit  = 300000;
   localparam int HoldCycles  = 200;
   localparam int ReportLimit = 10;
   localparam int PhaseItems  = 40;
   localparam int HoldItems   = 16;
   localparam int DrainCycles = 24;
   localparam int Predicted   = -1;

   // opcodes past the last instruction encode nothing
   localparam logic [4:0] OpFirstUnused = 5'd22;
   localparam logic [4:0] OpLastUnused  = 5'd31;

   localparam logic [7:0] RexW64      = 8'h48;
   localparam logic [7:0] RexPlain    = 8'h40;
   localparam logic [7:0] AluImm8     = 8'h83;
   localparam logic [7:0] AluImm32    = 8'h81;
   localparam logic [7:0] MovRm       = 8'h89;
   localparam logic [7:0] XorRm       = 8'h31;
   localparam logic [7:0] MovAbsOp    = 8'hB8;
   localparam logic [7:0] MovRmImm    = 8'hC7;
   localparam logic [7:0] CallRel     = 8'hE8;
   localparam logic [7:0] JmpRel      = 8'hE9;
   localparam logic [7:0] PushRbpByte = 8'h55;
   localparam logic [7:0] PopRbpByte  = 8'h5D;
   localparam logic [7:0] RetByte     = 8'hC3;
   localparam logic [7:0] NopByte     = 8'h90;

   localparam logic [3:0] AluExtAdd = 4'd0;
   localparam logic [3:0] AluExtSub = 4'd5;
   localparam logic [3:0] MovImmExt = 4'd0;
   localparam logic [3:0] RspNum    = 4'd4;
   localparam logic [3:0] RbpNum    = 4'd5;
   localparam logic [1:0] ModReg    = 2'd3;

   localparam logic [31:0] BoundaryLo [8] = '{32'h0000_007F, 32'h0000_0080, 32'hFFFF_FF80,
      32'hFFFF_FF7F, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

   typedef struct packed {
      logic [4:0]  opcode;
      logic [3:0]  dst_reg;
      logic [3:0]  src_reg;
      logic [63:0] imm;
      logic [1:0]  two_bit_field;
      logic [3:0]  rex_bits;
   } encode_req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last;
   } code_byte_type;

   typedef struct {
      encode_req_type req;
      int             n_known;
      logic [87:0]    known;   // first byte sits in the highest used lane
   } directed_row_type;

   logic clock;
   logic reset;

   x86ie_req_if req_ch ();
   x86ie_rsp_if rsp_ch ();

   x86_64_instruction_encoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   code_byte_type    expected_bytes [$];
   logic [7:0]       encoded [$];
   directed_row_type directed_rows [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void emit_le32(logic [31:0] v);
      for (int i = 0; i < 4; i++) encoded.push_back(v[8*i +: 8]);
   endfunction

   function automatic logic [7:0] modrm_byte(logic [1:0] md, logic [3:0] rg, logic [3:0] rm);
      return {md, rg[2:0], rm[2:0]};
   endfunction

   // 83 /ext ib when the value sign-extends from 8 bits, else 81 /ext id
   function automatic void emit_alu_imm(logic [3:0] ext, logic [3:0] rm, logic [31:0] v);
      logic short_form;
      short_form = ($signed(v) >= -128) && ($signed(v) <= 127);
      encoded.push_back(RexW64 | {7'd0, rm[3]});
      encoded.push_back(short_form ? AluImm8 : AluImm32);
      encoded.push_back(modrm_byte(ModReg, ext, rm));
      if (short_form) encoded.push_back(v[7:0]);
      else emit_le32(v);
   endfunction

   function automatic void emit_reg_reg(logic [7:0] op, logic [3:0] dst, logic [3:0] src);
      encoded.push_back(RexW64 | {5'd0, src[3], 1'b0, dst[3]});
      encoded.push_back(op);
      encoded.push_back(modrm_byte(ModReg, src, dst));
   endfunction

   function automatic void predict_encoding(encode_req_type r);
      logic [31:0] lo;
      lo = r.imm[31:0];
      encoded.delete();
      case (r.opcode)
         x86ie_pkg::OP_PUSH_RBP:      encoded.push_back(PushRbpByte);
         x86ie_pkg::OP_MOV_RBP_RSP:   emit_reg_reg(MovRm, RbpNum, RspNum);
         x86ie_pkg::OP_MOV_RSP_RBP:   emit_reg_reg(MovRm, RspNum, RbpNum);
         x86ie_pkg::OP_POP_RBP:       encoded.push_back(PopRbpByte);
         x86ie_pkg::OP_RET:           encoded.push_back(RetByte);
         x86ie_pkg::OP_SUB_RSP:       emit_alu_imm(AluExtSub, RspNum, lo);
         x86ie_pkg::OP_ADD_RSP:       emit_alu_imm(AluExtAdd, RspNum, lo);
         x86ie_pkg::OP_MOV_REG_IMM: begin
            encoded.push_back(RexW64 | {7'd0, r.dst_reg[3]});
            encoded.push_back(MovRmImm);
            encoded.push_back(modrm_byte(ModReg, MovImmExt, r.dst_reg));
            emit_le32(lo);
         end
         x86ie_pkg::OP_MOV_REG_REG:   emit_reg_reg(MovRm, r.dst_reg, r.src_reg);
         x86ie_pkg::OP_MOV_RAX_IMM64: begin
            encoded.push_back(RexW64);
            encoded.push_back(MovAbsOp);
            emit_le32(lo);
            emit_le32(r.imm[63:32]);
         end
         x86ie_pkg::OP_ADD_REG_IMM:   emit_alu_imm(AluExtAdd, r.dst_reg, lo);
         x86ie_pkg::OP_SUB_REG_IMM:   emit_alu_imm(AluExtSub, r.dst_reg, lo);
         x86ie_pkg::OP_XOR_REG_REG:   emit_reg_reg(XorRm, r.dst_reg, r.src_reg);
         x86ie_pkg::OP_CALL: begin
            encoded.push_back(CallRel);
            emit_le32(lo);
         end
         x86ie_pkg::OP_JMP: begin
            encoded.push_back(JmpRel);
            emit_le32(lo);
         end
         x86ie_pkg::OP_NOP:           encoded.push_back(NopByte);
         x86ie_pkg::OP_PROLOGUE: begin
            encoded.push_back(PushRbpByte);
            emit_reg_reg(MovRm, RbpNum, RspNum);
            // frame allocation only for a positive size
            if ($signed(lo) > 0) emit_alu_imm(AluExtSub, RspNum, lo);
         end
         x86ie_pkg::OP_EPILOGUE: begin
            emit_reg_reg(MovRm, RspNum, RbpNum);
            encoded.push_back(PopRbpByte);
            encoded.push_back(RetByte);
         end
         x86ie_pkg::OP_RAW_BYTE:      encoded.push_back(r.imm[7:0]);
         x86ie_pkg::OP_RAW_REX:       encoded.push_back(RexPlain | {4'd0, r.rex_bits});
         x86ie_pkg::OP_RAW_MODRM, x86ie_pkg::OP_RAW_SIB:
            encoded.push_back(modrm_byte(r.two_bit_field, r.dst_reg, r.src_reg));
         default: ;
      endcase
      foreach (encoded[i]) expected_bytes.push_back('{encoded[i], i == encoded.size() - 1});
   endfunction

   function automatic directed_row_type dir_row(logic [4:0] op, logic [3:0] dst,
                                                logic [3:0] src, logic [63:0] imm,
                                                logic [1:0] two, logic [3:0] rex,
                                                int n_known, logic [87:0] known);
      directed_row_type row;
      row.req     = '{op, dst, src, imm, two, rex};
      row.n_known = n_known;
      row.known   = known;
      return row;
   endfunction

   function automatic encode_req_type random_request();
      encode_req_type r;
      logic [7:0]     b;
      if ($urandom_range(99) < 6)
         r.opcode = 5'($urandom_range(OpLastUnused, OpFirstUnused));
      else
         r.opcode = 5'($urandom_range(x86ie_pkg::OP_RAW_SIB, x86ie_pkg::OP_PUSH_RBP));
      r.dst_reg       = 4'($urandom);
      r.src_reg       = 4'($urandom);
      r.two_bit_field = 2'($urandom);
      r.rex_bits      = 4'($urandom);
      r.imm           = {$urandom, $urandom};
      b               = 8'($urandom);
      case ($urandom_range(2))
         0:       r.imm[31:0] = {{24{b[7]}}, b};
         1:       r.imm[31:0] = BoundaryLo[$urandom_range(7)];
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_request(encode_req_type r, int n_known, logic [87:0] known);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= r.opcode;
      req_ch.dst_reg       <= r.dst_reg;
      req_ch.src_reg       <= r.src_reg;
      req_ch.imm           <= r.imm;
      req_ch.two_bit_field <= r.two_bit_field;
      req_ch.rex_bits      <= r.rex_bits;
      do @(posedge clock); while (!req_ch.ready);
      if (n_known == Predicted) predict_encoding(r);
      else
         for (int i = 0; i < n_known; i++)
            expected_bytes.push_back('{known[8*(n_known-1-i) +: 8], i == n_known - 1});
   endtask

   // only requests that encode something count toward the phase size
   task automatic run_phase(int idle_pct, int stall, int items);
      int             sent;
      encode_req_type r;
      sent          = 0;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      while (sent < items) begin
         r = random_request();
         send_request(r, Predicted, '0);
         if (r.opcode <= x86ie_pkg::OP_RAW_SIB) sent++;
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.opcode        = '0;
      req_ch.dst_reg       = '0;
      req_ch.src_reg       = '0;
      req_ch.imm           = '0;
      req_ch.two_bit_field = '0;
      req_ch.rex_bits      = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed_rows.push_back(dir_row(x86ie_pkg::OP_PUSH_RBP, 0, 0, 0, 0, 0, 1, 88'h55));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_POP_RBP, 0, 0, 0, 0, 0, 1, 88'h5D));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_RET, 0, 0, 0, 0, 0, 1, 88'hC3));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_NOP, 0, 0, 0, 0, 0, 1, 88'h90));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_MOV_RBP_RSP, 0, 0, 0, 0, 0, 3,
                                      88'h4889E5));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_MOV_RSP_RBP, 0, 0, 0, 0, 0, 3,
                                      88'h4889EC));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_EPILOGUE, 0, 0, 0, 0, 0, 5,
                                      88'h4889EC5DC3));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_RAW_BYTE, 15, 15, '1, 3, 15, 1, 88'hFF));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_RAW_REX, 0, 0, 0, 0, 15, 1, 88'h4F));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_RAW_MODRM, 15, 15, 0, 3, 0, 1, 88'hFF));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_RAW_SIB, 0, 0, 0, 0, 0, 1, 88'h00));
      directed_rows.push_back(dir_row(OpFirstUnused, 0, 0, 0, 0, 0, 0, 88'h0));
      directed_rows.push_back(dir_row(OpLastUnused, 15, 15, '1, 3, 15, 0, 88'h0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_PROLOGUE, 0, 0, 0, 0, 0, 4,
                                      88'h554889E5));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_SUB_RSP, 0, 0, 64'h7F, 0, 0, 4,
                                      88'h4883EC7F));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_SUB_RSP, 0, 0, 64'h80, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_ADD_RSP, 0, 0, '1 << 7, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_MOV_REG_IMM, 15, 0, 64'h8000_0000, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_MOV_REG_REG, 15, 8, 0, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_MOV_RAX_IMM64, 0, 0,
                                      64'h8000_0000_0000_0001, 0, 0, Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_ADD_REG_IMM, 8, 0, 64'h7FFF_FFFF, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_SUB_REG_IMM, 15, 0, '1, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_XOR_REG_REG, 0, 15, 0, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_CALL, 0, 0, 64'h8000_0000, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_JMP, 0, 0, '1, 0, 0, Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_PROLOGUE, 0, 0, 64'h7FFF_FFFF, 0, 0,
                                      Predicted, 0));
      directed_rows.push_back(dir_row(x86ie_pkg::OP_PROLOGUE, 0, 0, 64'h8000_0000, 0, 0,
                                      Predicted, 0));

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].n_known, directed_rows[i].known);

      run_phase(0, 0, PhaseItems);
      run_phase(81, 0, PhaseItems);
      run_phase(0, 81, PhaseItems);
      run_phase(37, 37, PhaseItems);

      // long receiver hold-off while requests keep coming, so the queue fills up
      hold_requests++;
      run_phase(0, 0, HoldItems);

      req_ch.valid <= 1'b0;
      stall_pct = 0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // checks each byte transfer against the expected stream
   initial begin
      code_byte_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bytes.size() == 0) begin
               error_count++;
               if (error_count <= ReportLimit)
                  $display("unexpected code byte %02h last %0b", rsp_ch.code_byte, rsp_ch.last);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.code_byte !== want.code_byte || rsp_ch.last !== want.last) begin
                  error_count++;
                  if (error_count <= ReportLimit)
                     $display("code byte mismatch: expected %02h last %0b, got %02h last %0b",
                              want.code_byte, want.last, rsp_ch.code_byte, rsp_ch.last);
               end
            end
         end
      end
   end

   // receiver: random stalls, plus the long hold-off counted here
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            hold_left  = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
